// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the stream find/replace RTL.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold whenever the antecedent holds, in the same cycle.
`define SFR_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/sfr_pkg.sv -----
// Shared types and constants for the stream find/replace core.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfr_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 4;
   localparam int LEN_CAP    = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_LEN    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_BYTES  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPLACE_LEN   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPLACE_BYTES = 2'd3;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [LEN_W-1:0]  len_type;

   // Per-cell window control
   typedef struct packed {
      logic sel;    // this cell takes the incoming byte
      logic write;  // a beat was accepted, update the cell
      logic shift;  // window slides by one toward cell 0
   } cell_ctl_type;

   // Burst load into the output buffer
   typedef struct packed {
      logic    valid;
      len_type count;
      logic    has;
      logic    last;
   } emit_load_type;

endpackage

`default_nettype wire

// ----- rtl/sfr_win_cell.sv -----
// One byte cell of the sliding match window.
// Depends on sfr_pkg; chained by stream_find_replace_core.
`default_nettype none

module sfr_win_cell (
   input  logic                  clock,
   input  sfr_pkg::cell_ctl_type ctl,
   input  sfr_pkg::byte_type     new_byte,
   input  sfr_pkg::byte_type     nbr_post,
   input  sfr_pkg::byte_type     tgt_byte,
   output sfr_pkg::byte_type     post_byte,
   output logic                  eq
);
   import sfr_pkg::*;

   byte_type win_ff;
   byte_type win_in;

   // value of this cell once the incoming byte is placed
   assign post_byte = ctl.sel ? new_byte : win_ff;
   assign eq        = (post_byte == tgt_byte);

   always_comb begin
      win_in = win_ff;
      if (ctl.write) begin
         win_in = ctl.shift ? nbr_post : post_byte;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

// ----- rtl/sfr_emit.sv -----
// Output burst buffer: loads up to DEPTH bytes at once, shifts one per beat.
// Depends on sfr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfr_emit #(
   parameter int DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sfr_pkg::emit_load_type load,
   input  sfr_pkg::byte_type      ld_bytes [DEPTH],
   input  logic                   out_ready,
   output logic                   out_valid,
   output sfr_pkg::byte_type      out_byte,
   output logic                   out_has,
   output logic                   out_last,
   output logic                   can_load
);
   import sfr_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   byte_type         buf_ff [DEPTH];
   byte_type         buf_in [DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             has_ff, has_in;
   logic             last_ff, last_in;
   logic             take;

   assign out_valid = (cnt_ff != '0);
   assign out_byte  = buf_ff[0];
   assign out_has   = has_ff;
   assign out_last  = last_ff && (cnt_ff == CNT_W'(1));
   assign take      = out_valid && out_ready;
   assign can_load  = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && out_ready);

   for (genvar j = 0; j < DEPTH; j++) begin : g_buf
      if (j == DEPTH - 1) begin : g_tail
         assign buf_in[j] = load.valid ? ld_bytes[j] : (take ? '0 : buf_ff[j]);
      end else begin : g_body
         assign buf_in[j] = load.valid ? ld_bytes[j] : (take ? buf_ff[j+1] : buf_ff[j]);
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      has_in  = has_ff;
      last_in = last_ff;
      if (load.valid) begin
         cnt_in  = CNT_W'(load.count);
         has_in  = load.has;
         last_in = load.last;
      end else if (take) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         has_ff  <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         has_ff  <= has_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   `SFR_ASSERT_IMPL(a_no_overrun, load.valid,
      (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && out_ready),
      "burst loaded over undelivered beats")
   `SFR_ASSERT_IMPL(a_load_count, load.valid,
      (load.count != '0) && (load.count <= LEN_W'(DEPTH)),
      "burst length out of range")
   `SFR_ASSERT_NEXT(a_drain_step, take && !load.valid && (cnt_ff > CNT_W'(1)),
      cnt_ff == $past(cnt_ff) - CNT_W'(1),
      "buffer count did not step on a taken beat")

endmodule

`default_nettype wire

// ----- rtl/stream_find_replace_core.sv -----
// Streaming find/replace: a chain of window cells compares against the target,
// an output buffer serializes the resulting bytes.
// Depends on sfr_pkg, sfr_win_cell, sfr_emit and assert_macros.svh.
//
// The first result beat is registered and presented in the cycle after the input beat.
// Throughput: one input byte per cycle while each byte yields at most one beat and
//   rsp_tready is high; a byte that yields several beats (replacement or flush) holds
//   the input until the single output port of the burst buffer has sent them.
// Reset (synchronous, active high): clears the registers, window fill and buffer.
`default_nettype none
`include "assert_macros.svh"

module stream_find_replace_core #(
   parameter int MAX_TARGET  = 8,
   parameter int MAX_REPLACE = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sfr_pkg::BYTE_W-1:0]         req_tdata,   // [7:0] in_byte
   input  logic                               req_tlast,   // in_last
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sfr_pkg::BYTE_W-1:0]         rsp_tdata,   // [7:0] out_byte
   output logic                               rsp_tuser,   // [0] has_byte
   output logic                               rsp_tlast,   // out_last
   // register writes
   input  logic                               csr_we,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sfr_pkg::*;

   localparam int WIN_DEPTH  = (MAX_TARGET  < LEN_CAP) ? MAX_TARGET  : LEN_CAP;
   localparam int REP_DEPTH  = (MAX_REPLACE < LEN_CAP) ? MAX_REPLACE : LEN_CAP;
   localparam int EMIT_DEPTH = (WIN_DEPTH > REP_DEPTH) ? WIN_DEPTH : REP_DEPTH;

   // configuration
   len_type  tlen_ff, tlen_in;
   len_type  rlen_ff, rlen_in;
   byte_type tgt_ff [WIN_DEPTH];
   byte_type tgt_in [WIN_DEPTH];
   byte_type rep_ff [REP_DEPTH];
   byte_type rep_in [REP_DEPTH];

   len_type  fill_ff, fill_in;
   len_type  tlen_eff, rlen_eff;
   len_type  fill_cur, fill_nx;
   logic     accept, pass, full, match;

   cell_ctl_type  cell_ctl [WIN_DEPTH];
   byte_type      post     [WIN_DEPTH];
   byte_type      nbr      [WIN_DEPTH];
   logic          eq       [WIN_DEPTH];

   byte_type      post_pad [EMIT_DEPTH];
   byte_type      rep_pad  [EMIT_DEPTH];
   byte_type      ld_bytes [EMIT_DEPTH];
   emit_load_type ld;

   assign tlen_eff = (tlen_ff > LEN_W'(WIN_DEPTH)) ? LEN_W'(WIN_DEPTH) : tlen_ff;
   assign rlen_eff = (rlen_ff > LEN_W'(REP_DEPTH)) ? LEN_W'(REP_DEPTH) : rlen_ff;

   assign accept   = req_tvalid && req_tready;
   assign pass     = (tlen_eff == '0);
   assign fill_cur = (fill_ff >= tlen_eff) ? '0 : fill_ff;
   assign fill_nx  = fill_cur + LEN_W'(1);
   assign full     = (fill_nx == tlen_eff);

   // ------------------------------------------------------------------
   // register writes
   // ------------------------------------------------------------------
   always_comb begin
      tlen_in = tlen_ff;
      rlen_in = rlen_ff;
      tgt_in  = tgt_ff;
      rep_in  = rep_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_TARGET_LEN: begin
               tlen_in = csr_wdata[LEN_W-1:0];
            end
            CSR_TARGET_BYTES: begin
               for (int i = 0; i < WIN_DEPTH; i++) begin
                  tgt_in[i] = csr_wdata[i*BYTE_W +: BYTE_W];
               end
            end
            CSR_REPLACE_LEN: begin
               rlen_in = csr_wdata[LEN_W-1:0];
            end
            CSR_REPLACE_BYTES: begin
               for (int i = 0; i < REP_DEPTH; i++) begin
                  rep_in[i] = csr_wdata[i*BYTE_W +: BYTE_W];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlen_ff <= '0;
         rlen_ff <= '0;
         for (int i = 0; i < WIN_DEPTH; i++) begin
            tgt_ff[i] <= '0;
         end
         for (int i = 0; i < REP_DEPTH; i++) begin
            rep_ff[i] <= '0;
         end
      end else begin
         tlen_ff <= tlen_in;
         rlen_ff <= rlen_in;
         tgt_ff  <= tgt_in;
         rep_ff  <= rep_in;
      end
   end

   // ------------------------------------------------------------------
   // window cell chain
   // ------------------------------------------------------------------
   for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
      if (i == WIN_DEPTH - 1) begin : g_end
         assign nbr[i] = '0;
      end else begin : g_mid
         assign nbr[i] = post[i+1];
      end

      assign cell_ctl[i].sel   = (fill_cur == LEN_W'(i));
      assign cell_ctl[i].write = accept && !pass;
      assign cell_ctl[i].shift = full && !match;

      sfr_win_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .new_byte  (req_tdata),
         .nbr_post  (nbr[i]),
         .tgt_byte  (tgt_ff[i]),
         .post_byte (post[i]),
         .eq        (eq[i])
      );
   end

   always_comb begin
      match = 1'b1;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if ((LEN_W'(i) < tlen_eff) && !eq[i]) begin
            match = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // burst selection
   // ------------------------------------------------------------------
   for (genvar j = 0; j < EMIT_DEPTH; j++) begin : g_pad
      if (j < WIN_DEPTH) begin : g_win
         assign post_pad[j] = post[j];
      end else begin : g_nowin
         assign post_pad[j] = '0;
      end
      if (j < REP_DEPTH) begin : g_rep
         assign rep_pad[j] = rep_ff[j];
      end else begin : g_norep
         assign rep_pad[j] = '0;
      end
   end

   always_comb begin
      ld.count = '0;
      ld.has   = 1'b1;
      ld.last  = req_tlast;
      fill_in  = fill_ff;
      for (int j = 0; j < EMIT_DEPTH; j++) begin
         ld_bytes[j] = post_pad[j];
      end

      if (pass) begin
         ld.count = LEN_W'(1);
         for (int j = 0; j < EMIT_DEPTH; j++) begin
            ld_bytes[j] = (j == 0) ? req_tdata : '0;
         end
      end else if (full && match) begin
         if (rlen_eff != '0) begin
            ld.count = rlen_eff;
            ld_bytes = rep_pad;
         end else if (req_tlast) begin
            // bare end marker
            ld.count = LEN_W'(1);
            ld.has   = 1'b0;
            for (int j = 0; j < EMIT_DEPTH; j++) begin
               ld_bytes[j] = '0;
            end
         end
      end else if (full) begin
         ld.count = req_tlast ? tlen_eff : LEN_W'(1);
      end else begin
         ld.count = req_tlast ? fill_nx : '0;
      end

      if (accept) begin
         if (pass || req_tlast || (full && match)) begin
            fill_in = '0;
         end else if (full) begin
            fill_in = tlen_eff - LEN_W'(1);
         end else begin
            fill_in = fill_nx;
         end
      end
      // a new target length drops whatever the window holds
      if (csr_we && (csr_addr == CSR_TARGET_LEN)) begin
         fill_in = '0;
      end

      ld.valid = accept && (ld.count != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   sfr_emit #(
      .DEPTH (EMIT_DEPTH)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (ld),
      .ld_bytes  (ld_bytes),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_byte  (rsp_tdata),
      .out_has   (rsp_tuser),
      .out_last  (rsp_tlast),
      .can_load  (req_tready)
   );

   `SFR_ASSERT_IMPL(a_fill_below_len, tlen_eff != '0, fill_ff < tlen_eff,
      "window fill reached the target length between beats")
   `SFR_ASSERT_IMPL(a_marker_is_last, rsp_tvalid && !rsp_tuser, rsp_tlast,
      "bare marker beat without end of stream")
   `SFR_ASSERT_NEXT(a_last_empties, accept && req_tlast && !csr_we, fill_ff == '0,
      "window not emptied after the last byte")

endmodule

`default_nettype wire
